### design/dkdr_pkg.sv
// Shared constants, payload types and cell bus types for the display registry.
`timescale 1ns / 1ps
`default_nettype none
package dkdr_pkg;

   localparam int DEPTH   = 64;
   localparam int SLOT_W  = $clog2(DEPTH);
   localparam int USED_W  = $clog2(DEPTH + 1);
   localparam int KEY_W   = 31;
   localparam int TYPE_W  = 8;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 16;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [STAT_W-1:0] status_type;

   localparam cmd_type CMD_FETCH_SERIAL = 2'd0;
   localparam cmd_type CMD_FETCH_NUMBER = 2'd1;
   localparam cmd_type CMD_RECONCILE    = 2'd2;

   localparam status_type STAT_FOUND    = 2'd0;
   localparam status_type STAT_CREATED  = 2'd1;
   localparam status_type STAT_UPDATED  = 2'd2;
   localparam status_type STAT_REJECTED = 2'd3;

   typedef struct packed {
      cmd_type             cmd;
      logic [KEY_W-1:0]    lookup_key;
      logic [KEY_W-1:0]    serial_number;
      logic [KEY_W-1:0]    display_number;
      logic [TYPE_W-1:0]   display_type;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  entry_index;
      status_type          status;
      logic [KEY_W-1:0]    entry_serial;
      logic [KEY_W-1:0]    entry_number;
      logic [TYPE_W-1:0]   entry_type;
      logic [COUNT_W-1:0]  change_count;
   } rsp_payload_type;

   // search token that walks the cell row, collecting the hits
   typedef struct packed {
      logic                valid;
      logic                ser_en;
      logic [KEY_W-1:0]    ser_key;
      logic                num_en;
      logic [KEY_W-1:0]    num_key;
      logic                ser_hit;
      logic [SLOT_W-1:0]   ser_slot;
      logic [KEY_W-1:0]    ser_number;
      logic [TYPE_W-1:0]   ser_dtype;
      logic                num_hit;
      logic [SLOT_W-1:0]   num_slot;
      logic [KEY_W-1:0]    num_serial;
      logic [TYPE_W-1:0]   num_dtype;
   } token_type;

   // write broadcast: one full entry write plus one number unbind
   typedef struct packed {
      logic                pri_en;
      logic [SLOT_W-1:0]   pri_slot;
      logic [KEY_W-1:0]    pri_serial;
      logic [KEY_W-1:0]    pri_number;
      logic [TYPE_W-1:0]   pri_dtype;
      logic                sec_en;
      logic [SLOT_W-1:0]   sec_slot;
   } write_type;

endpackage
`default_nettype wire

### design/dkdr_if.sv
// Valid/ready channel interfaces for the request and response words.
`timescale 1ns / 1ps
`default_nettype none
interface dkdr_req_if;
   logic                     valid;
   logic                     ready;
   dkdr_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface dkdr_rsp_if;
   logic                     valid;
   logic                     ready;
   dkdr_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### design/dkdr_cell.sv
// One registry slot: stored entry, key compare and one stage of the search token.
`timescale 1ns / 1ps
`default_nettype none
module dkdr_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [dkdr_pkg::SLOT_W-1:0] cell_slot,
   input  wire dkdr_pkg::token_type         tok_prev,
   input  wire dkdr_pkg::write_type         write,
   output dkdr_pkg::token_type              tok_next
);

   logic                          valid_ff;
   logic [dkdr_pkg::KEY_W-1:0]    serial_ff;
   logic [dkdr_pkg::KEY_W-1:0]    number_ff;
   logic [dkdr_pkg::TYPE_W-1:0]   dtype_ff;
   dkdr_pkg::token_type           token_ff;
   dkdr_pkg::token_type           token_in;
   logic                          ser_match;
   logic                          num_match;

   assign ser_match = valid_ff && tok_prev.ser_en && (serial_ff == tok_prev.ser_key);
   assign num_match = valid_ff && tok_prev.num_en && (number_ff == tok_prev.num_key);

   always_comb begin
      token_in = tok_prev;
      // first match wins; keys are unique anyway
      if (ser_match && !tok_prev.ser_hit) begin
         token_in.ser_hit    = 1'b1;
         token_in.ser_slot   = cell_slot;
         token_in.ser_number = number_ff;
         token_in.ser_dtype  = dtype_ff;
      end
      if (num_match && !tok_prev.num_hit) begin
         token_in.num_hit    = 1'b1;
         token_in.num_slot   = cell_slot;
         token_in.num_serial = serial_ff;
         token_in.num_dtype  = dtype_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         token_ff <= '0;
      end else begin
         token_ff <= token_in;
         if (write.pri_en && (write.pri_slot == cell_slot)) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (write.pri_en && (write.pri_slot == cell_slot)) begin
         serial_ff <= write.pri_serial;
         dtype_ff  <= write.pri_dtype;
      end
      // unbind and entry write never target the same slot
      if (write.sec_en && (write.sec_slot == cell_slot)) begin
         number_ff <= '0;
      end else if (write.pri_en && (write.pri_slot == cell_slot)) begin
         number_ff <= write.pri_number;
      end
   end

   assign tok_next = token_ff;

endmodule
`default_nettype wire

### design/dual_key_display_registry.sv
// Top level: request control, row of slot cells and response register.
`timescale 1ns / 1ps
`default_nettype none
// Registry of DEPTH device entries keyed by serial and by position number.
// Each request launches a search token down a row of DEPTH slot cells, one cell
// per clock; the token collects the serial and number hits, then the finish
// state decides the command, broadcasts the writes and loads the response word,
// waiting first for any earlier response to be taken. One request is in flight
// at a time; the wait for the response is set by the length of the cell row. A
// new request is taken once the response word is loaded, while that response
// still waits on rsp.ready.
// No clearing pass is needed after reset.
module dual_key_display_registry (
   input  wire logic   clock,
   input  wire logic   reset,
   dkdr_req_if.sink    req,
   dkdr_rsp_if.source  rsp
);

   typedef enum logic [2:0] {
      STATE_IDLE   = 3'b001,
      STATE_SEARCH = 3'b010,
      STATE_FINISH = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   dkdr_pkg::req_payload_type        cmd_ff;
   dkdr_pkg::token_type              head_ff, head_in;
   dkdr_pkg::token_type              hold_ff;
   dkdr_pkg::token_type              chain [dkdr_pkg::DEPTH+1];
   logic [dkdr_pkg::USED_W-1:0]      used_ff, used_in;
   logic [dkdr_pkg::COUNT_W-1:0]     total_ff, total_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   dkdr_pkg::rsp_payload_type        rsp_ff, rsp_in;
   dkdr_pkg::write_type              write;

   logic                             accept;
   logic                             finish;
   logic                             full;
   logic [dkdr_pkg::SLOT_W-1:0]      new_slot;
   logic [dkdr_pkg::SLOT_W-1:0]      res_slot;
   logic                             res_ok;
   dkdr_pkg::status_type             res_status;
   logic [dkdr_pkg::KEY_W-1:0]       res_serial;
   logic [dkdr_pkg::KEY_W-1:0]       res_number;
   logic [dkdr_pkg::TYPE_W-1:0]      res_dtype;
   logic [1:0]                       bumps;
   logic                             grow;

   assign req.ready = (state_ff == STATE_IDLE) && !reset;
   assign accept    = req.valid && req.ready;
   assign finish    = (state_ff == STATE_FINISH) && (!rsp_valid_ff || rsp.ready);

   // search token launch
   always_comb begin
      head_in         = '0;
      head_in.valid   = accept;
      head_in.ser_key = req.payload.serial_number;
      head_in.num_key = req.payload.display_number;
      case (req.payload.cmd)
         dkdr_pkg::CMD_FETCH_SERIAL: begin
            head_in.ser_key = req.payload.lookup_key;
            head_in.ser_en  = (req.payload.lookup_key != '0);
         end
         dkdr_pkg::CMD_FETCH_NUMBER: begin
            head_in.num_key = req.payload.lookup_key;
            head_in.num_en  = (req.payload.lookup_key != '0);
         end
         dkdr_pkg::CMD_RECONCILE: begin
            head_in.ser_en = (req.payload.serial_number != '0);
            head_in.num_en = (req.payload.display_number != '0);
         end
         default: begin
            head_in.ser_en = 1'b0;
         end
      endcase
   end

   assign chain[0] = head_ff;

   for (genvar i = 0; i < dkdr_pkg::DEPTH; i++) begin : g_cell
      dkdr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_slot (dkdr_pkg::SLOT_W'(i)),
         .tok_prev  (chain[i]),
         .write     (write),
         .tok_next  (chain[i+1])
      );
   end

   assign full     = (used_ff >= dkdr_pkg::USED_W'(dkdr_pkg::DEPTH));
   assign new_slot = used_ff[dkdr_pkg::SLOT_W-1:0];

   // command decision on the collected hits
   always_comb begin
      write      = '0;
      res_ok     = 1'b0;
      res_status = dkdr_pkg::STAT_REJECTED;
      res_slot   = '0;
      res_serial = '0;
      res_number = '0;
      res_dtype  = '0;
      bumps      = 2'd0;
      grow       = 1'b0;
      case (cmd_ff.cmd)
         dkdr_pkg::CMD_FETCH_SERIAL: begin
            if (cmd_ff.lookup_key != '0) begin
               if (hold_ff.ser_hit) begin
                  res_ok     = 1'b1;
                  res_status = dkdr_pkg::STAT_FOUND;
                  res_slot   = hold_ff.ser_slot;
                  res_serial = cmd_ff.lookup_key;
                  res_number = hold_ff.ser_number;
                  res_dtype  = hold_ff.ser_dtype;
               end else if (!full) begin
                  res_ok     = 1'b1;
                  res_status = dkdr_pkg::STAT_CREATED;
                  res_slot   = new_slot;
                  res_serial = cmd_ff.lookup_key;
                  grow       = 1'b1;
               end
            end
         end
         dkdr_pkg::CMD_FETCH_NUMBER: begin
            if (cmd_ff.lookup_key != '0) begin
               if (hold_ff.num_hit) begin
                  res_ok     = 1'b1;
                  res_status = dkdr_pkg::STAT_FOUND;
                  res_slot   = hold_ff.num_slot;
                  res_serial = hold_ff.num_serial;
                  res_number = cmd_ff.lookup_key;
                  res_dtype  = hold_ff.num_dtype;
               end else if (!full) begin
                  res_ok     = 1'b1;
                  res_status = dkdr_pkg::STAT_CREATED;
                  res_slot   = new_slot;
                  res_number = cmd_ff.lookup_key;
                  grow       = 1'b1;
               end
            end
         end
         dkdr_pkg::CMD_RECONCILE: begin
            res_serial = cmd_ff.serial_number;
            res_number = cmd_ff.display_number;
            res_dtype  = cmd_ff.display_type;
            if (hold_ff.ser_hit) begin
               res_ok   = 1'b1;
               res_slot = hold_ff.ser_slot;
               if (hold_ff.num_hit && (hold_ff.num_slot == hold_ff.ser_slot)) begin
                  res_status = dkdr_pkg::STAT_FOUND;
                  res_dtype  = hold_ff.ser_dtype;
               end else begin
                  // move the serial's entry, unbinding the number's old holder
                  res_status    = dkdr_pkg::STAT_UPDATED;
                  write.pri_en  = 1'b1;
                  write.sec_en  = hold_ff.num_hit;
                  write.sec_slot = hold_ff.num_slot;
                  bumps         = hold_ff.num_hit ? 2'd2 : 2'd1;
               end
            end else if (hold_ff.num_hit) begin
               // adopt the serial into the number's entry
               res_ok       = 1'b1;
               res_status   = dkdr_pkg::STAT_UPDATED;
               res_slot     = hold_ff.num_slot;
               write.pri_en = 1'b1;
               bumps        = 2'd1;
            end else if ((cmd_ff.serial_number != '0) || (cmd_ff.display_number != '0)) begin
               if (!full) begin
                  res_ok     = 1'b1;
                  res_status = dkdr_pkg::STAT_CREATED;
                  res_slot   = new_slot;
                  grow       = 1'b1;
                  bumps      = 2'd1;
               end
            end
         end
         default: begin
            res_ok = 1'b0;
         end
      endcase
      if (grow) begin
         write.pri_en = 1'b1;
      end
      write.pri_slot   = res_slot;
      write.pri_serial = res_serial;
      write.pri_number = res_number;
      write.pri_dtype  = res_dtype;
      if (!finish) begin
         write.pri_en = 1'b0;
         write.sec_en = 1'b0;
      end
      if (!res_ok) begin
         res_slot   = '0;
         res_serial = '0;
         res_number = '0;
         res_dtype  = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      total_in     = total_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               state_in = STATE_SEARCH;
            end
         end
         STATE_SEARCH: begin
            if (chain[dkdr_pkg::DEPTH].valid) begin
               state_in = STATE_FINISH;
            end
         end
         STATE_FINISH: begin
            if (finish) begin
               state_in     = STATE_IDLE;
               used_in      = used_ff + dkdr_pkg::USED_W'(grow);
               total_in     = total_ff + dkdr_pkg::COUNT_W'(bumps);
               rsp_valid_in = 1'b1;
               rsp_in.entry_index  = dkdr_pkg::INDEX_W'(res_slot);
               rsp_in.status       = res_status;
               rsp_in.entry_serial = res_serial;
               rsp_in.entry_number = res_number;
               rsp_in.entry_type   = res_dtype;
               rsp_in.change_count = total_in;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_IDLE;
         used_ff       <= '0;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         head_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         total_ff      <= total_in;
         rsp_valid_ff  <= rsp_valid_in;
         head_ff       <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff             <= rsp_in;
      if (accept) begin
         cmd_ff <= req.payload;
      end
      if (state_ff == STATE_SEARCH) begin
         hold_ff <= chain[dkdr_pkg::DEPTH];
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

endmodule
`default_nettype wire
